// ===== sv/tgc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the touch gesture classifier.
// No dependencies; every other file imports this package.
package tgc_pkg;

  localparam int SLOTS      = 2;
  localparam int MAXRES     = 2;
  localparam int COORD_W    = 12;
  localparam int TIME_W     = 32;
  localparam int LPT_W      = 16;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);
  localparam int PUSH_W     = $clog2(MAXRES + 1);

  localparam logic [CFG_ADDR_W-1:0] CFG_PANEL_WIDTH  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_MOVE_THRESH  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_LONG_PRESS   = 2'd2;

  localparam logic [COORD_W-1:0] PANEL_WIDTH_RST = 12'd320;
  localparam logic [COORD_W-1:0] MOVE_THRESH_RST = 12'd10;
  localparam logic [LPT_W-1:0]   LONG_PRESS_RST  = 16'd800;

  localparam logic       CMD_TICK       = 1'b0;
  localparam logic       CMD_SAMPLE     = 1'b1;
  localparam logic [1:0] RAW_EV_CONTACT = 2'd2;

  typedef enum logic [2:0] {
    EV_PRESS        = 3'd0,
    EV_MOVE_START   = 3'd1,
    EV_LONG_START   = 3'd2,
    EV_SHORT_CLICK  = 3'd3,
    EV_LONG_RELEASE = 3'd4,
    EV_MOVE_RELEASE = 3'd5
  } event_kind_e;

  typedef struct packed {
    event_kind_e        kind;
    logic               slot;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [TIME_W-1:0]  dur;
    logic               last;
  } res_t;

  typedef struct packed {
    logic [PUSH_W-1:0] cnt;
    res_t              ent0;
    res_t              ent1;
  } q_push_t;

  typedef struct packed {
    logic valid;
    logic room;
    res_t head;
  } q_stat_t;

endpackage

// ===== sv/tgc_front.sv =====
`timescale 1ns / 1ps
// Front end: configuration registers, per-slot gesture state and classification.
// Depends on tgc_pkg; pushes up to two result beats per item into tgc_queue.
module tgc_front import tgc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  command_i,
  input  logic                  slot_i,
  input  logic                  present_i,
  input  logic [7:0]            raw_xh_i,
  input  logic [7:0]            raw_xl_i,
  input  logic [7:0]            raw_yh_i,
  input  logic [7:0]            raw_yl_i,
  input  q_stat_t               q_stat_i,
  output q_push_t               push_o
);

  logic [COORD_W-1:0] panel_width_q, move_thresh_q;
  logic [LPT_W-1:0]   long_press_q;
  logic [TIME_W-1:0]  time_q;

  logic               wp_q    [SLOTS];
  logic               touch_q [SLOTS];
  logic               mov_q   [SLOTS];
  logic               lf_q    [SLOTS];
  logic [COORD_W-1:0] cx_q    [SLOTS];
  logic [COORD_W-1:0] cy_q    [SLOTS];
  logic [COORD_W-1:0] sx_q    [SLOTS];
  logic [COORD_W-1:0] sy_q    [SLOTS];
  logic [TIME_W-1:0]  st_q    [SLOTS];

  logic               accept, is_tick, slot_ok;
  logic               sel  [SLOTS];
  logic               fire [SLOTS];
  logic [COORD_W-1:0] raw_x, x, y, dx, dy;
  logic               s_wp, s_mv, s_lf;
  logic [COORD_W-1:0] s_cx, s_cy, s_sx, s_sy;
  logic [TIME_W-1:0]  s_st, dur_s, time_nxt;
  logic               press, contact, release_s, pos_upd, mv_start;
  logic [PUSH_W-1:0]  nfire;
  event_kind_e        rel_kind;

  assign in_stall_o = !q_stat_i.room;
  assign accept     = in_valid_i && q_stat_i.room;
  assign is_tick    = (command_i == CMD_TICK);
  assign slot_ok    = (32'(slot_i) < SLOTS);
  assign time_nxt   = time_q + 1'b1;

  // Coordinate decode: x is mirrored against the panel width and clamps at zero.
  assign raw_x = {raw_yh_i[3:0], raw_yl_i};
  assign x     = (raw_x > panel_width_q) ? '0 : panel_width_q - raw_x;
  assign y     = {raw_xh_i[3:0], raw_xl_i};

  always_comb begin
    s_wp = 1'b0; s_mv = 1'b0; s_lf = 1'b0;
    s_cx = '0; s_cy = '0; s_sx = '0; s_sy = '0; s_st = '0;
    for (int i = 0; i < SLOTS; i++) begin
      sel[i] = !is_tick && slot_ok && (32'(slot_i) == i);
      if (sel[i]) begin
        s_wp = wp_q[i]; s_mv = mov_q[i]; s_lf = lf_q[i];
        s_cx = cx_q[i]; s_cy = cy_q[i]; s_sx = sx_q[i]; s_sy = sy_q[i];
        s_st = st_q[i];
      end
    end
  end

  assign press     = slot_ok && present_i && !s_wp;
  assign contact   = slot_ok && present_i && s_wp;
  assign release_s = slot_ok && !present_i && s_wp;
  assign pos_upd   = contact && ((x != s_cx) || (y != s_cy)) &&
                     (raw_xh_i[7:6] == RAW_EV_CONTACT);
  assign dx        = (x > s_sx) ? x - s_sx : s_sx - x;
  assign dy        = (y > s_sy) ? y - s_sy : s_sy - y;
  assign mv_start  = pos_upd && !s_mv && ((dx > move_thresh_q) || (dy > move_thresh_q));
  assign dur_s     = time_q - s_st;
  assign rel_kind  = s_mv ? EV_MOVE_RELEASE : (s_lf ? EV_LONG_RELEASE : EV_SHORT_CLICK);

  always_comb begin
    logic [TIME_W-1:0] held;
    res_t              r;
    push_o = '0;
    nfire  = '0;
    r      = '0;
    held   = '0;
    if (is_tick) begin
      // Long presses are reported in slot order, at most two per tick.
      for (int i = 0; i < SLOTS; i++) begin
        held    = time_nxt - st_q[i];
        fire[i] = touch_q[i] && !mov_q[i] && !lf_q[i] &&
                  (held > TIME_W'(long_press_q)) && (nfire < PUSH_W'(MAXRES));
        if (fire[i]) begin
          r = '{kind: EV_LONG_START, slot: 1'(i), x: cx_q[i], y: cy_q[i],
                dur: held, last: 1'b0};
          if (nfire == '0) push_o.ent0 = r;
          else             push_o.ent1 = r;
          nfire = nfire + 1'b1;
        end
      end
    end else begin
      for (int i = 0; i < SLOTS; i++) fire[i] = 1'b0;
      if (press) begin
        push_o.ent0 = '{kind: EV_PRESS, slot: slot_i, x: x, y: y, dur: '0, last: 1'b0};
        nfire = PUSH_W'(1);
      end else if (mv_start) begin
        push_o.ent0 = '{kind: EV_MOVE_START, slot: slot_i, x: x, y: y, dur: dur_s,
                        last: 1'b0};
        nfire = PUSH_W'(1);
      end else if (release_s) begin
        push_o.ent0 = '{kind: rel_kind, slot: slot_i, x: s_cx, y: s_cy, dur: dur_s,
                        last: 1'b0};
        nfire = PUSH_W'(1);
      end
    end
    if (nfire == PUSH_W'(1)) push_o.ent0.last = 1'b1;
    if (nfire == PUSH_W'(2)) push_o.ent1.last = 1'b1;
    push_o.cnt = accept ? nfire : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      panel_width_q <= PANEL_WIDTH_RST;
      move_thresh_q <= MOVE_THRESH_RST;
      long_press_q  <= LONG_PRESS_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_PANEL_WIDTH: panel_width_q <= cfg_wdata_i[COORD_W-1:0];
        CFG_MOVE_THRESH: move_thresh_q <= cfg_wdata_i[COORD_W-1:0];
        CFG_LONG_PRESS:  long_press_q  <= cfg_wdata_i[LPT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        wp_q[i] <= 1'b0; touch_q[i] <= 1'b0; mov_q[i] <= 1'b0; lf_q[i] <= 1'b0;
        cx_q[i] <= '0; cy_q[i] <= '0; sx_q[i] <= '0; sy_q[i] <= '0; st_q[i] <= '0;
      end
    end else if (accept) begin
      if (is_tick) time_q <= time_nxt;
      for (int i = 0; i < SLOTS; i++) begin
        if (fire[i]) lf_q[i] <= 1'b1;
        if (sel[i]) begin
          wp_q[i] <= present_i;
          if (press) begin
            cx_q[i] <= x; cy_q[i] <= y; sx_q[i] <= x; sy_q[i] <= y;
            st_q[i] <= time_q;
            touch_q[i] <= 1'b1; mov_q[i] <= 1'b0; lf_q[i] <= 1'b0;
          end else if (pos_upd) begin
            cx_q[i] <= x; cy_q[i] <= y;
            if (mv_start) mov_q[i] <= 1'b1;
          end else if (release_s) begin
            cx_q[i] <= '0; cy_q[i] <= '0; sx_q[i] <= '0; sy_q[i] <= '0;
            st_q[i] <= '0;
            touch_q[i] <= 1'b0; mov_q[i] <= 1'b0; lf_q[i] <= 1'b0;
          end
        end
      end
    end
  end

endmodule

// ===== sv/tgc_queue.sv =====
`timescale 1ns / 1ps
// Result queue between front and back: up to two writes and one read per cycle.
// Depends on tgc_pkg.
module tgc_queue import tgc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  q_push_t push_i,
  input  logic    pop_i,
  output q_stat_t stat_o
);

  res_t              ent_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic [QPTR_W-1:0] wr_ptr1;

  assign wr_ptr1      = wr_ptr_q + 1'b1;
  assign stat_o.valid = (count_q != '0);
  // Room is kept for the largest burst one item can cause.
  assign stat_o.room  = (count_q <= QCNT_W'(QDEPTH - MAXRES));
  assign stat_o.head  = ent_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != '0) ent_q[wr_ptr_q] <= push_i.ent0;
    if (push_i.cnt == PUSH_W'(2)) ent_q[wr_ptr1] <= push_i.ent1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QPTR_W'(push_i.cnt);
      if (pop_i) rd_ptr_q <= rd_ptr_q + 1'b1;
      count_q <= count_q + QCNT_W'(push_i.cnt) - QCNT_W'(pop_i);
    end
  end

endmodule

// ===== sv/tgc_back.sv =====
`timescale 1ns / 1ps
// Back end: output register that takes beats from the queue and presents them.
// Depends on tgc_pkg.
module tgc_back import tgc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  q_stat_t            q_stat_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         event_kind_o,
  output logic               event_slot_o,
  output logic [COORD_W-1:0] pos_x_o,
  output logic [COORD_W-1:0] pos_y_o,
  output logic [TIME_W-1:0]  duration_o,
  output logic               last_o
);

  res_t out_q;
  logic out_valid_q;

  assign pop_o = q_stat_i.valid && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i) begin
    if (pop_o) out_q <= q_stat_i.head;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign event_kind_o = out_q.kind;
  assign event_slot_o = out_q.slot;
  assign pos_x_o      = out_q.x;
  assign pos_y_o      = out_q.y;
  assign duration_o   = out_q.dur;
  assign last_o       = out_q.last;

endmodule

// ===== sv/touch_gesture_classifier_unit.sv =====
`timescale 1ns / 1ps
// Touch gesture classifier for two touch slots: press, move, long press, release.
//
// Input channel (in_valid_i / in_stall_o): one beat is either a time tick
// (command 0) or a touch sample for one slot with its four raw controller bytes.
// Output channel (out_valid_o / out_stall_i): one beat per gesture event;
// last_o marks the final event caused by an input beat. An input beat causes
// zero, one or two events.
// Configuration: cfg_we_i writes cfg_wdata_i into the register at cfg_addr_i
// (0 panel width, 1 move threshold, 2 long press ticks) at the clock edge.
// An event caused by an accepted beat passes through the result queue into the
// output register. Throughput: one input beat per cycle while in_stall_o is low.
// The output register drains the result queue at one event per cycle, so beats
// that cause two events fill the four-entry queue, and in_stall_o rises while it
// holds three or more events. A stalled receiver holds the output register and
// backs up into the queue. Reset clears time, all slot state and the queue and
// restores the register reset values; the block accepts beats right after reset.
module touch_gesture_classifier_unit import tgc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  command_i,
  input  logic                  slot_i,
  input  logic                  present_i,
  input  logic [7:0]            raw_xh_i,
  input  logic [7:0]            raw_xl_i,
  input  logic [7:0]            raw_yh_i,
  input  logic [7:0]            raw_yl_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [2:0]            event_kind_o,
  output logic                  event_slot_o,
  output logic [COORD_W-1:0]    pos_x_o,
  output logic [COORD_W-1:0]    pos_y_o,
  output logic [TIME_W-1:0]     duration_o,
  output logic                  last_o
);

  q_push_t push;
  q_stat_t q_stat;
  logic    pop;

  tgc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .slot_i      (slot_i),
    .present_i   (present_i),
    .raw_xh_i    (raw_xh_i),
    .raw_xl_i    (raw_xl_i),
    .raw_yh_i    (raw_yh_i),
    .raw_yl_i    (raw_yl_i),
    .q_stat_i    (q_stat),
    .push_o      (push)
  );

  tgc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .stat_o (q_stat)
  );

  tgc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_stat_i     (q_stat),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .event_kind_o (event_kind_o),
    .event_slot_o (event_slot_o),
    .pos_x_o      (pos_x_o),
    .pos_y_o      (pos_y_o),
    .duration_o   (duration_o),
    .last_o       (last_o)
  );

endmodule

// ===== sv/tgc_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks of the touch gesture classifier, bound to the top level.
// Depends on tgc_pkg and touch_gesture_classifier_unit.
module tgc_checker import tgc_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [2:0]            event_kind_o,
  input logic                  event_slot_o,
  input logic [COORD_W-1:0]    pos_x_o,
  input logic [COORD_W-1:0]    pos_y_o,
  input logic [TIME_W-1:0]     duration_o,
  input logic                  last_o
);

  // A stalled beat stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(event_kind_o) &&
      $stable(event_slot_o) && $stable(pos_x_o) && $stable(pos_y_o) &&
      $stable(duration_o) && $stable(last_o))
    else $error("output beat changed while stalled");

  // The block is ready right after reset because the queue is empty.
  a_ready_after_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !in_stall_o)
    else $error("input stalled right after reset");

  // A press starts the hold, so it always carries a zero duration.
  a_press_dur: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_kind_o == EV_PRESS) |-> (duration_o == '0))
    else $error("press event with nonzero duration");

  // A press is always the only event of its sample.
  a_press_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_kind_o == EV_PRESS) |-> last_o)
    else $error("press event not marked last");

endmodule

bind touch_gesture_classifier_unit tgc_checker u_tgc_checker (.*);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for touch_gesture_classifier_unit: a queue-fed driver,
// a monitor with its own gesture predictor, and phases over several register settings.
// Depends on tgc_pkg for widths, register indexes, command codes and event kinds.
module testbench;
  import tgc_pkg::*;

  localparam int IDLE_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic       command;
    logic       slot;
    logic       present;
    logic [7:0] raw_xh;
    logic [7:0] raw_xl;
    logic [7:0] raw_yh;
    logic [7:0] raw_yl;
  } touch_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  command = 1'b0;
  logic                  slot = 1'b0;
  logic                  present = 1'b0;
  logic [7:0]            raw_xh = '0;
  logic [7:0]            raw_xl = '0;
  logic [7:0]            raw_yh = '0;
  logic [7:0]            raw_yl = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [2:0]            event_kind;
  logic                  event_slot;
  logic [COORD_W-1:0]    pos_x;
  logic [COORD_W-1:0]    pos_y;
  logic [TIME_W-1:0]     duration;
  logic                  last;

  touch_gesture_classifier_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_addr_i  (cfg_addr),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .command_i   (command),
    .slot_i      (slot),
    .present_i   (present),
    .raw_xh_i    (raw_xh),
    .raw_xl_i    (raw_xl),
    .raw_yh_i    (raw_yh),
    .raw_yl_i    (raw_yl),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .event_kind_o(event_kind),
    .event_slot_o(event_slot),
    .pos_x_o     (pos_x),
    .pos_y_o     (pos_y),
    .duration_o  (duration),
    .last_o      (last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Gesture predictor state and its copy of the registers.
  logic [COORD_W-1:0] panel_w;
  logic [COORD_W-1:0] move_thr;
  logic [LPT_W-1:0]   long_ticks;
  logic [TIME_W-1:0]  clock_ticks;
  logic               slot_down  [SLOTS];
  logic [COORD_W-1:0] slot_x     [SLOTS];
  logic [COORD_W-1:0] slot_y     [SLOTS];
  logic [COORD_W-1:0] origin_x   [SLOTS];
  logic [COORD_W-1:0] origin_y   [SLOTS];
  logic [TIME_W-1:0]  hold_start [SLOTS];
  logic               touching   [SLOTS];
  logic               moving     [SLOTS];
  logic               long_fired [SLOTS];

  touch_beat_t pending_beats [$];
  res_t        expected_events [$];

  // Generator view of each slot, used to build well-formed gestures.
  logic               gen_down [SLOTS];
  logic [COORD_W-1:0] gen_rawx [SLOTS];
  logic [COORD_W-1:0] gen_y    [SLOTS];

  int failures = 0;
  int beats_accepted = 0;
  int ticks_accepted = 0;
  int events_checked = 0;
  int settings_used = 0;
  int hold_requests = 0;

  function automatic logic [COORD_W-1:0] coord_dist(input logic [COORD_W-1:0] a,
                                                    input logic [COORD_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic res_t make_event(input event_kind_e kind, input logic s,
                                      input logic [COORD_W-1:0] x,
                                      input logic [COORD_W-1:0] y,
                                      input logic [TIME_W-1:0] dur);
    res_t r;
    r.kind = kind;
    r.slot = s;
    r.x    = x;
    r.y    = y;
    r.dur  = dur;
    r.last = 1'b0;
    return r;
  endfunction

  task automatic reset_gestures();
    panel_w     = PANEL_WIDTH_RST;
    move_thr    = MOVE_THRESH_RST;
    long_ticks  = LONG_PRESS_RST;
    clock_ticks = '0;
    for (int i = 0; i < SLOTS; i++) begin
      slot_down[i]  = 1'b0;
      slot_x[i]     = '0;
      slot_y[i]     = '0;
      origin_x[i]   = '0;
      origin_y[i]   = '0;
      hold_start[i] = '0;
      touching[i]   = 1'b0;
      moving[i]     = 1'b0;
      long_fired[i] = 1'b0;
      gen_down[i]   = 1'b0;
      gen_rawx[i]   = '0;
      gen_y[i]      = '0;
    end
  endtask

  // Works out the gesture events that one accepted beat causes.
  task automatic classify_beat(input touch_beat_t b);
    res_t               found [MAXRES];
    int                 n;
    logic [COORD_W-1:0] raw_x;
    logic [COORD_W-1:0] nx;
    logic [COORD_W-1:0] ny;
    logic [TIME_W-1:0]  held;
    logic               s;
    event_kind_e        rel_kind;
    n = 0;
    if (b.command == CMD_TICK) begin
      clock_ticks = clock_ticks + 32'd1;
      for (int i = 0; i < SLOTS; i++) begin
        held = clock_ticks - hold_start[i];
        if (n < MAXRES && touching[i] && !moving[i] && !long_fired[i] &&
            held > {16'd0, long_ticks}) begin
          long_fired[i] = 1'b1;
          found[n] = make_event(EV_LONG_START, i[0], slot_x[i], slot_y[i], held);
          n++;
        end
      end
    end else begin
      raw_x = {b.raw_yh[3:0], b.raw_yl};
      nx    = (raw_x > panel_w) ? '0 : panel_w - raw_x;
      ny    = {b.raw_xh[3:0], b.raw_xl};
      s     = b.slot;
      if (b.present && !slot_down[s]) begin
        slot_x[s]     = nx;
        slot_y[s]     = ny;
        origin_x[s]   = nx;
        origin_y[s]   = ny;
        hold_start[s] = clock_ticks;
        touching[s]   = 1'b1;
        long_fired[s] = 1'b0;
        moving[s]     = 1'b0;
        found[n] = make_event(EV_PRESS, s, nx, ny, '0);
        n++;
      end else if (b.present && slot_down[s]) begin
        if ((nx != slot_x[s] || ny != slot_y[s]) && b.raw_xh[7:6] == RAW_EV_CONTACT) begin
          slot_x[s] = nx;
          slot_y[s] = ny;
          if (!moving[s] && (coord_dist(nx, origin_x[s]) > move_thr ||
                             coord_dist(ny, origin_y[s]) > move_thr)) begin
            moving[s] = 1'b1;
            found[n] = make_event(EV_MOVE_START, s, nx, ny, clock_ticks - hold_start[s]);
            n++;
          end
        end
      end else if (!b.present && slot_down[s]) begin
        if (moving[s]) rel_kind = EV_MOVE_RELEASE;
        else if (long_fired[s]) rel_kind = EV_LONG_RELEASE;
        else rel_kind = EV_SHORT_CLICK;
        found[n] = make_event(rel_kind, s, slot_x[s], slot_y[s],
                              clock_ticks - hold_start[s]);
        n++;
        slot_x[s]     = '0;
        slot_y[s]     = '0;
        origin_x[s]   = '0;
        origin_y[s]   = '0;
        hold_start[s] = '0;
        touching[s]   = 1'b0;
        moving[s]     = 1'b0;
        long_fired[s] = 1'b0;
      end
      slot_down[s] = b.present;
    end
    for (int k = 0; k < n; k++) begin
      found[k].last = (k == n - 1);
      expected_events.push_back(found[k]);
    end
  endtask

  // Driver: bursts of beats with random gaps in between.
  int burst_left;
  int gap_left;
  touch_beat_t beat_on_port;

  always @(posedge clk) begin
    touch_beat_t nb;
    if (!rst_n) begin
      in_valid   <= 1'b0;
      burst_left = $urandom_range(1, 24);
      gap_left   = 0;
    end else begin
      if (in_valid && !in_stall) begin
        classify_beat(beat_on_port);
        beats_accepted++;
        if (beat_on_port.command == CMD_TICK) ticks_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_beats.size() > 0) begin
          nb = pending_beats.pop_front();
          beat_on_port = nb;
          command  <= nb.command;
          slot     <= nb.slot;
          present  <= nb.present;
          raw_xh   <= nb.raw_xh;
          raw_xl   <= nb.raw_xl;
          raw_yh   <= nb.raw_yh;
          raw_yl   <= nb.raw_yl;
          in_valid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 10);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each event beat against the oldest prediction and drives stall.
  int stall_pct;
  int win_left;
  int hold_left;
  int holds_served;

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      out_stall    <= 1'b0;
      stall_pct    = 0;
      win_left     = 0;
      hold_left    = 0;
      holds_served = 0;
    end else begin
      if (out_valid && !out_stall) begin
        events_checked++;
        if (expected_events.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("unexpected event: kind %0d slot %0d x %0d y %0d dur %0d last %0d",
                     event_kind, event_slot, pos_x, pos_y, duration, last);
        end else begin
          want = expected_events.pop_front();
          if (want.kind !== event_kind || want.slot !== event_slot ||
              want.x !== pos_x || want.y !== pos_y ||
              want.dur !== duration || want.last !== last) begin
            failures++;
            if (failures <= 10) begin
              $display("event %0d expected: kind %0d slot %0d x %0d y %0d dur %0d last %0d",
                       events_checked, want.kind, want.slot, want.x, want.y,
                       want.dur, want.last);
              $display("event %0d actual:   kind %0d slot %0d x %0d y %0d dur %0d last %0d",
                       events_checked, event_kind, event_slot, pos_x, pos_y,
                       duration, last);
            end
          end
        end
      end
      if (holds_served != hold_requests) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (win_left <= 0) begin
          case ($urandom_range(0, 2))
            0: stall_pct = 0;
            1: stall_pct = 25;
            default: stall_pct = 60;
          endcase
          win_left = $urandom_range(8, 40);
        end
        win_left--;
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a beat.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d idle cycles, %0d events outstanding",
               idle_cycles, expected_events.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic touch_beat_t sample_beat(input logic s, input logic pres,
                                              input logic [1:0] ev, input logic [5:0] spare,
                                              input logic [COORD_W-1:0] rawx,
                                              input logic [COORD_W-1:0] y);
    touch_beat_t b;
    b.command = CMD_SAMPLE;
    b.slot    = s;
    b.present = pres;
    b.raw_xh  = {ev, spare[5:4], y[11:8]};
    b.raw_xl  = y[7:0];
    b.raw_yh  = {spare[3:0], rawx[11:8]};
    b.raw_yl  = rawx[7:0];
    return b;
  endfunction

  function automatic touch_beat_t tick_beat();
    touch_beat_t b;
    b = touch_beat_t'({$urandom, $urandom});
    b.command = CMD_TICK;
    return b;
  endfunction

  task automatic enqueue_beat(input touch_beat_t b);
    pending_beats.push_back(b);
    if (b.command == CMD_SAMPLE) begin
      gen_down[b.slot] = b.present;
      gen_rawx[b.slot] = {b.raw_yh[3:0], b.raw_yl};
      gen_y[b.slot]    = {b.raw_xh[3:0], b.raw_xl};
    end
  endtask

  task automatic queue_directed();
    enqueue_beat(tick_beat());
    // Absent while absent.
    enqueue_beat(sample_beat(1'b0, 1'b0, 2'd0, 6'd0, 12'd0, 12'd0));
    enqueue_beat(sample_beat(1'b0, 1'b1, 2'd0, 6'd0, 12'd0, 12'd0));
    // Contact at the same place, then a moved one without the contact code.
    enqueue_beat(sample_beat(1'b0, 1'b1, RAW_EV_CONTACT, 6'd0, 12'd0, 12'd0));
    enqueue_beat(sample_beat(1'b0, 1'b1, 2'd1, 6'd0, 12'd5, 12'd3));
    enqueue_beat(sample_beat(1'b0, 1'b1, RAW_EV_CONTACT, 6'd0, 12'd5, 12'd3));
    repeat (4) enqueue_beat(tick_beat());
    enqueue_beat(sample_beat(1'b0, 1'b0, 2'd0, 6'd0, 12'd0, 12'd0));
    // Raw x beyond the panel width clamps to zero.
    enqueue_beat(sample_beat(1'b1, 1'b1, 2'd3, 6'h3F, 12'hFFF, 12'hFFF));
    enqueue_beat(sample_beat(1'b1, 1'b1, RAW_EV_CONTACT, 6'h2A, 12'hFFF, 12'd4075));
    enqueue_beat(sample_beat(1'b1, 1'b0, 2'd3, 6'h3F, 12'hFFF, 12'hFFF));
    enqueue_beat(sample_beat(1'b0, 1'b1, 2'd1, 6'h15, 12'd320, 12'd100));
    enqueue_beat(sample_beat(1'b0, 1'b0, 2'd1, 6'h15, 12'd320, 12'd100));
    // Both slots held still: one tick reports two long presses.
    enqueue_beat(sample_beat(1'b0, 1'b1, RAW_EV_CONTACT, 6'd7, 12'd10, 12'd20));
    enqueue_beat(sample_beat(1'b1, 1'b1, RAW_EV_CONTACT, 6'd9, 12'd30, 12'd40));
    repeat (4) enqueue_beat(tick_beat());
    enqueue_beat(sample_beat(1'b1, 1'b0, 2'd0, 6'd0, 12'd0, 12'd0));
    enqueue_beat(sample_beat(1'b0, 1'b0, 2'd0, 6'd0, 12'd0, 12'd0));
  endtask

  // Mostly well-formed gestures on random slots, mixed with ticks and raw noise.
  task automatic queue_random_items(input int count);
    int                 roll;
    int                 span;
    int                 dx;
    int                 dy;
    logic               s;
    logic [1:0]         ev;
    logic [COORD_W-1:0] rx;
    logic [COORD_W-1:0] ry;
    touch_beat_t        b;
    span = ((move_thr > 12'd40) ? 40 : int'(move_thr)) + 4;
    for (int k = 0; k < count; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        b = touch_beat_t'({$urandom, $urandom});
        enqueue_beat(b);
      end else if (roll < 38) begin
        enqueue_beat(tick_beat());
      end else begin
        s = 1'($urandom_range(0, 1));
        roll = $urandom_range(0, 99);
        if (!gen_down[s]) begin
          rx = $urandom_range(0, 1) ? 12'($urandom_range(0, panel_w)) : 12'($urandom);
          ry = 12'($urandom);
          enqueue_beat(sample_beat(s, roll < 80, 2'($urandom), 6'($urandom), rx, ry));
        end else if (roll < 12) begin
          enqueue_beat(sample_beat(s, 1'b0, 2'($urandom), 6'($urandom),
                                   12'($urandom), 12'($urandom)));
        end else if (roll < 22) begin
          if ($urandom_range(0, 1)) begin
            ev = 2'($urandom_range(0, 2));
            if (ev == RAW_EV_CONTACT) ev = 2'd3;
            enqueue_beat(sample_beat(s, 1'b1, ev, 6'($urandom),
                                     12'($urandom), 12'($urandom)));
          end else begin
            enqueue_beat(sample_beat(s, 1'b1, RAW_EV_CONTACT, 6'($urandom),
                                     gen_rawx[s], gen_y[s]));
          end
        end else begin
          dx = int'($urandom_range(0, 2 * span)) - span;
          dy = int'($urandom_range(0, 2 * span)) - span;
          rx = 12'(int'(gen_rawx[s]) + dx);
          ry = 12'(int'(gen_y[s]) + dy);
          enqueue_beat(sample_beat(s, 1'b1, RAW_EV_CONTACT, 6'($urandom), rx, ry));
        end
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_PANEL_WIDTH: panel_w    = value[COORD_W-1:0];
      CFG_MOVE_THRESH: move_thr   = value[COORD_W-1:0];
      CFG_LONG_PRESS:  long_ticks = value[LPT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [CFG_DATA_W-1:0] pw,
                                input logic [CFG_DATA_W-1:0] thr,
                                input logic [CFG_DATA_W-1:0] lpt);
    write_reg(CFG_PANEL_WIDTH, pw);
    write_reg(CFG_MOVE_THRESH, thr);
    write_reg(CFG_LONG_PRESS, lpt);
    settings_used++;
  endtask

  // Waits until every beat is taken and every event has come, then lets a
  // few cycles pass in case a beat with no event is still in flight.
  task automatic wait_quiet();
    do @(negedge clk);
    while (pending_beats.size() != 0 || in_valid || expected_events.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  initial begin
    reset_gestures();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    settings_used = 1;

    queue_random_items(100);
    wait_quiet();

    apply_settings(16'd320, 16'd10, 16'd3);
    queue_directed();
    wait_quiet();

    apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_random_items(150);
    wait_quiet();

    apply_settings(16'h0000, 16'h0000, 16'h0000);
    queue_random_items(150);
    wait_quiet();

    // The receiver holds off while this phase is offered, backing up the block.
    apply_settings(16'd320, 16'd10, 16'd5);
    queue_random_items(200);
    hold_requests++;
    wait_quiet();

    repeat (5) begin
      apply_settings(16'($urandom_range(100, 900)) | (16'($urandom_range(0, 15)) << 12),
                     16'($urandom_range(0, 30)) | (16'($urandom_range(0, 15)) << 12),
                     16'($urandom_range(0, 12)));
      queue_random_items(100);
      wait_quiet();
    end

    repeat (20) @(negedge clk);
    if (expected_events.size() != 0) begin
      failures += expected_events.size();
      $display("%0d predicted events never arrived", expected_events.size());
    end
    $display("ran %0d beats (%0d ticks) under %0d register settings, %0d events checked",
             beats_accepted, ticks_accepted, settings_used, events_checked);
    $display("including one long receiver hold-off and %0d failures", failures);
    if (failures == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/tgc_pkg.sv
sv/tgc_front.sv
sv/tgc_queue.sv
sv/tgc_back.sv
sv/touch_gesture_classifier_unit.sv
sv/tgc_checker.sv
tb/sv/testbench.sv
